[hw/rtl/itaf_pkg.sv]
// ----------------------------------------------------------------------------
// itaf_pkg: shared types, constants and microcode for the integer formatter
// Holds the control word layout, the program ROM and the character codes.
// ----------------------------------------------------------------------------
package itaf_pkg;

  localparam int unsigned OUT_LIMIT_DEF = 62;
  localparam int unsigned VAL_W         = 64;
  localparam int unsigned ND_MAX        = 20;           // decimal digits of 2^64-1
  localparam int unsigned BCD_W         = 4 * ND_MAX;
  localparam int unsigned ND_W          = 5;
  localparam int unsigned CNT_W         = 7;
  localparam int unsigned DABBLE_N      = VAL_W;
  localparam int unsigned UPC_W         = 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_MINUS = 8'h2d;  // '-'
  localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_UX    = 8'h58;  // 'X'
  localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
  localparam logic [7:0] CH_QUEST = 8'h3f;  // '?'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [3:0] DEC_BASE = 4'd10;

  typedef enum logic [2:0] {
    UOP_WAIT,
    UOP_NOP,
    UOP_DABBLE,
    UOP_NORM,
    UOP_CALC,
    UOP_EMIT
  } uop_e;

  typedef enum logic [2:0] {
    CHR_QUEST,
    CHR_SPACE,
    CHR_MINUS,
    CHR_ZERO,
    CHR_X,
    CHR_DIGIT
  } chr_e;

  // repeat count of a step, loaded when the step is entered
  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_DABBLE,
    SRC_QLEN,
    SRC_SP,
    SRC_NEG,
    SRC_PFX,
    SRC_Z,
    SRC_ND
  } src_e;

  typedef enum logic [1:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_OVF
  } jc_e;

  typedef struct packed {
    uop_e             op;
    chr_e             chr;
    src_e             src;
    jc_e              jc;
    logic [UPC_W-1:0] tgt;
  } ucw_t;

  typedef struct packed {
    uop_e op;
    chr_e chr;
    logic fire;
  } ctl_t;

  typedef struct packed {
    logic             out_free;
    logic             top_zero;
    logic             nd_gt1;
    logic             ovf;
    logic             rem_zero;
    logic [CNT_W-1:0] cnt_dabble;
    logic [CNT_W-1:0] cnt_qlen;
    logic [CNT_W-1:0] cnt_sp;
    logic [CNT_W-1:0] cnt_neg;
    logic [CNT_W-1:0] cnt_pfx;
    logic [CNT_W-1:0] cnt_z;
    logic [CNT_W-1:0] cnt_nd;
  } sts_t;

  localparam logic [UPC_W-1:0] STEP_WAIT   = 4'd0;
  localparam logic [UPC_W-1:0] STEP_SETTLE = 4'd1;
  localparam logic [UPC_W-1:0] STEP_DABBLE = 4'd2;
  localparam logic [UPC_W-1:0] STEP_NORM   = 4'd3;
  localparam logic [UPC_W-1:0] STEP_CALC   = 4'd4;
  localparam logic [UPC_W-1:0] STEP_ARM    = 4'd5;
  localparam logic [UPC_W-1:0] STEP_QFILL  = 4'd6;
  localparam logic [UPC_W-1:0] STEP_SPACE  = 4'd7;
  localparam logic [UPC_W-1:0] STEP_MINUS  = 4'd8;
  localparam logic [UPC_W-1:0] STEP_PFX0   = 4'd9;
  localparam logic [UPC_W-1:0] STEP_PFXX   = 4'd10;
  localparam logic [UPC_W-1:0] STEP_ZEROS  = 4'd11;
  localparam logic [UPC_W-1:0] STEP_DIGITS = 4'd12;

  function automatic ucw_t ucode(logic [UPC_W-1:0] a);
    ucw_t w;
    w = '{op: UOP_NOP, chr: CHR_QUEST, src: SRC_NONE, jc: JC_NEVER, tgt: STEP_WAIT};
    case (a)
      STEP_WAIT:   w.op = UOP_WAIT;
      STEP_SETTLE: w.op = UOP_NOP;
      STEP_DABBLE: begin w.op = UOP_DABBLE; w.src = SRC_DABBLE; end
      STEP_NORM:   w.op = UOP_NORM;
      STEP_CALC:   w.op = UOP_CALC;
      STEP_ARM:    w.op = UOP_NOP;
      STEP_QFILL:  begin
        w.op = UOP_EMIT; w.chr = CHR_QUEST; w.src = SRC_QLEN; w.jc = JC_OVF;
      end
      STEP_SPACE:  begin w.op = UOP_EMIT; w.chr = CHR_SPACE; w.src = SRC_SP;  end
      STEP_MINUS:  begin w.op = UOP_EMIT; w.chr = CHR_MINUS; w.src = SRC_NEG; end
      STEP_PFX0:   begin w.op = UOP_EMIT; w.chr = CHR_ZERO;  w.src = SRC_PFX; end
      STEP_PFXX:   begin w.op = UOP_EMIT; w.chr = CHR_X;     w.src = SRC_PFX; end
      STEP_ZEROS:  begin w.op = UOP_EMIT; w.chr = CHR_ZERO;  w.src = SRC_Z;   end
      STEP_DIGITS: begin
        w.op = UOP_EMIT; w.chr = CHR_DIGIT; w.src = SRC_ND; w.jc = JC_ALWAYS;
      end
      default:     begin w.op = UOP_WAIT; w.jc = JC_ALWAYS; end
    endcase
    return w;
  endfunction

  function automatic logic [7:0] digit_char(logic [3:0] d, logic up);
    logic [7:0] letter;
    letter = up ? CH_UA : CH_LA;
    if (d < DEC_BASE) begin
      return CH_ZERO + {4'd0, d};
    end
    return letter + {4'd0, d - DEC_BASE};
  endfunction

endpackage

[hw/rtl/itaf_seq.sv]
// ----------------------------------------------------------------------------
// itaf_seq: microcode sequencer
// Step counter, repeat counter and conditional jumps over the program ROM.
// ----------------------------------------------------------------------------
module itaf_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  itaf_pkg::sts_t sts_i,
  output itaf_pkg::ctl_t ctl_o,
  output logic           in_ready_o
);

  logic [itaf_pkg::UPC_W-1:0] upc_q, upc_d, upc_nxt;
  logic [itaf_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_nw;
  itaf_pkg::ucw_t             uw, nw;
  logic                       fire, done, taken;

  always_comb begin
    uw   = itaf_pkg::ucode(upc_q);
    fire = 1'b0;
    done = 1'b0;
    case (uw.op)
      itaf_pkg::UOP_WAIT: begin
        fire = in_valid_i;
        done = in_valid_i;
      end
      itaf_pkg::UOP_DABBLE: begin
        if (cnt_q == '0) done = 1'b1;
        else             fire = 1'b1;
      end
      itaf_pkg::UOP_EMIT: begin
        if (cnt_q == '0) done = 1'b1;
        else             fire = sts_i.out_free;
      end
      itaf_pkg::UOP_NORM: begin
        // drop leading zero digits, keep at least one
        if (sts_i.top_zero && sts_i.nd_gt1) fire = 1'b1;
        else                                 done = 1'b1;
      end
      default: begin
        fire = 1'b1;
        done = 1'b1;
      end
    endcase

    taken   = (uw.jc == itaf_pkg::JC_ALWAYS) || ((uw.jc == itaf_pkg::JC_OVF) && sts_i.ovf);
    upc_nxt = taken ? uw.tgt : upc_q + 1'b1;
    nw      = itaf_pkg::ucode(upc_nxt);

    case (nw.src)
      itaf_pkg::SRC_DABBLE: cnt_nw = sts_i.cnt_dabble;
      itaf_pkg::SRC_QLEN:   cnt_nw = sts_i.cnt_qlen;
      itaf_pkg::SRC_SP:     cnt_nw = sts_i.cnt_sp;
      itaf_pkg::SRC_NEG:    cnt_nw = sts_i.cnt_neg;
      itaf_pkg::SRC_PFX:    cnt_nw = sts_i.cnt_pfx;
      itaf_pkg::SRC_Z:      cnt_nw = sts_i.cnt_z;
      itaf_pkg::SRC_ND:     cnt_nw = sts_i.cnt_nd;
      default:              cnt_nw = '0;
    endcase

    upc_d = done ? upc_nxt : upc_q;
    if (done) begin
      cnt_d = cnt_nw;
    end else if (fire && (uw.op == itaf_pkg::UOP_DABBLE || uw.op == itaf_pkg::UOP_EMIT)) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= itaf_pkg::STEP_WAIT;
      cnt_q <= '0;
    end else begin
      upc_q <= upc_d;
      cnt_q <= cnt_d;
    end
  end

  assign ctl_o.op   = uw.op;
  assign ctl_o.chr  = uw.chr;
  assign ctl_o.fire = fire;
  assign in_ready_o = (uw.op == itaf_pkg::UOP_WAIT);

endmodule

[hw/rtl/itaf_dp.sv]
// ----------------------------------------------------------------------------
// itaf_dp: formatter datapath
// Operand load, double-dabble digit unit, layout arithmetic, output register.
// ----------------------------------------------------------------------------
module itaf_dp #(
  parameter int unsigned OUT_LIMIT = itaf_pkg::OUT_LIMIT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  itaf_pkg::ctl_t              ctl_i,
  output itaf_pkg::sts_t              sts_o,
  input  logic [itaf_pkg::VAL_W-1:0]  value_i,
  input  logic                        wide_i,
  input  logic                        is_signed_i,
  input  logic                        kind_i,
  input  logic                        upper_case_i,
  input  logic                        hex_prefix_i,
  input  logic                        zero_pad_i,
  input  logic [7:0]                  field_width_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  char_out_o,
  output logic                        last_o
);

  localparam int unsigned FW_W  = $clog2(OUT_LIMIT);
  localparam int unsigned REM_W = $clog2(OUT_LIMIT + 2);
  localparam int unsigned VW    = itaf_pkg::VAL_W;
  localparam int unsigned BW    = itaf_pkg::BCD_W;
  localparam int unsigned NW    = itaf_pkg::ND_W;
  localparam int unsigned CW    = itaf_pkg::CNT_W;

  logic [VW-1:0]    bin_q;
  logic [BW-1:0]    bcd_q, adj;
  logic [NW-1:0]    nd_q;
  logic             neg_q, hex_q, up_q, pfx_q, zp_q;
  logic [FW_W-1:0]  fw_q, sp_q, z_q;
  logic             ovf_q;
  logic [REM_W-1:0] rem_q;
  logic             out_valid_q, out_last_q;
  logic [7:0]       out_char_q;

  logic [VW-1:0]    mag_w, mag;
  logic [31:0]      mag_n;
  logic             top_bit, neg_in;
  logic [FW_W-1:0]  fw_in, nd_ext, fwe, s, sp_c, z_c, plen;
  logic [REM_W-1:0] total_c;
  logic             ovf_c, emit;
  logic [7:0]       chr_sel;

  // operand magnitude; only signed decimal is negated
  always_comb begin
    mag_w   = '0 - value_i;
    mag_n   = 32'd0 - value_i[31:0];
    top_bit = wide_i ? value_i[VW-1] : value_i[31];
    neg_in  = is_signed_i & ~kind_i & top_bit;
    if (wide_i) mag = neg_in ? mag_w : value_i;
    else        mag = {32'd0, (neg_in ? mag_n : value_i[31:0])};
    fw_in   = (field_width_i >= 8'(OUT_LIMIT)) ? FW_W'(OUT_LIMIT - 1)
                                              : field_width_i[FW_W-1:0];
  end

  // add-3 correction on every BCD digit before the shift
  always_comb begin
    adj = bcd_q;
    for (int i = 0; i < itaf_pkg::ND_MAX; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
    end
  end

  // layout: spaces, sign, prefix, zeros, digits
  always_comb begin
    nd_ext  = FW_W'(nd_q);
    fwe     = (fw_q > nd_ext) ? fw_q : nd_ext;
    s       = fwe - nd_ext;
    plen    = FW_W'({pfx_q, neg_q});
    if (zp_q) begin
      sp_c = '0;
      z_c  = (s > plen) ? s - plen : '0;
    end else begin
      // the minus sign takes the place of the last space
      sp_c = (neg_q && s != '0) ? s - 1'b1 : s;
      z_c  = '0;
    end
    total_c = REM_W'(sp_c) + REM_W'(neg_q) + (pfx_q ? REM_W'(2) : '0)
            + REM_W'(z_c) + REM_W'(nd_q);
    ovf_c   = total_c > REM_W'(OUT_LIMIT - 1);
  end

  always_comb begin
    case (ctl_i.chr)
      itaf_pkg::CHR_QUEST: chr_sel = itaf_pkg::CH_QUEST;
      itaf_pkg::CHR_SPACE: chr_sel = itaf_pkg::CH_SPACE;
      itaf_pkg::CHR_MINUS: chr_sel = itaf_pkg::CH_MINUS;
      itaf_pkg::CHR_ZERO:  chr_sel = itaf_pkg::CH_ZERO;
      itaf_pkg::CHR_X:     chr_sel = up_q ? itaf_pkg::CH_UX : itaf_pkg::CH_LX;
      itaf_pkg::CHR_DIGIT: chr_sel = itaf_pkg::digit_char(bcd_q[BW-1 -: 4], up_q);
      default:             chr_sel = itaf_pkg::CH_QUEST;
    endcase
  end

  assign emit = ctl_i.fire && (ctl_i.op == itaf_pkg::UOP_EMIT);

  always_ff @(posedge clk_i) begin
    if (ctl_i.fire) begin
      case (ctl_i.op)
        itaf_pkg::UOP_WAIT: begin
          bin_q <= mag;
          bcd_q <= kind_i ? BW'(mag) : '0;
          nd_q  <= NW'(itaf_pkg::ND_MAX);
          neg_q <= neg_in;
          hex_q <= kind_i;
          up_q  <= upper_case_i;
          pfx_q <= kind_i & hex_prefix_i;
          zp_q  <= zero_pad_i;
          fw_q  <= fw_in;
        end
        itaf_pkg::UOP_DABBLE: begin
          bcd_q <= {adj[BW-2:0], bin_q[VW-1]};
          bin_q <= bin_q << 1;
        end
        itaf_pkg::UOP_NORM: begin
          bcd_q <= bcd_q << 4;
          nd_q  <= nd_q - 1'b1;
        end
        itaf_pkg::UOP_CALC: begin
          sp_q <= sp_c;
          z_q  <= z_c;
        end
        itaf_pkg::UOP_EMIT: begin
          out_char_q <= chr_sel;
          out_last_q <= (rem_q == REM_W'(1));
          if (ctl_i.chr == itaf_pkg::CHR_DIGIT) bcd_q <= bcd_q << 4;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (ctl_i.fire && ctl_i.op == itaf_pkg::UOP_CALC) begin
        ovf_q <= ovf_c;
        rem_q <= ovf_c ? REM_W'(OUT_LIMIT - 1) : total_c;
      end else if (emit) begin
        rem_q <= rem_q - 1'b1;
      end
    end
  end

  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign sts_o.top_zero   = (bcd_q[BW-1 -: 4] == 4'd0);
  assign sts_o.nd_gt1     = (nd_q > NW'(1));
  assign sts_o.ovf        = ovf_q;
  assign sts_o.rem_zero   = (rem_q == '0);
  assign sts_o.cnt_dabble = hex_q ? '0 : CW'(itaf_pkg::DABBLE_N);
  assign sts_o.cnt_qlen   = ovf_q ? CW'(OUT_LIMIT - 1) : '0;
  assign sts_o.cnt_sp     = CW'(sp_q);
  assign sts_o.cnt_neg    = CW'(neg_q);
  assign sts_o.cnt_pfx    = CW'(pfx_q);
  assign sts_o.cnt_z      = CW'(z_q);
  assign sts_o.cnt_nd     = CW'(nd_q);

  assign out_valid_o = out_valid_q;
  assign char_out_o  = out_char_q;
  assign last_o      = out_last_q;

endmodule

[hw/rtl/integer_to_ascii_formatter_top.sv]
// Timing: a decimal item first runs the 64-step double-dabble loop, a hex
//   item skips it; the characters then go out one per cycle while the output
//   is not stalled.
// Throughput: one item at a time; input ready returns in the cycle after the
//   last character of the run has been loaded into the output register.
// Reset: asynchronous, active low; the block comes up waiting for an item.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top: printf-style integer to ASCII converter
// Microcoded sequencer driving a digit unit and a character output stage.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top #(
  parameter int unsigned OUT_LIMIT = itaf_pkg::OUT_LIMIT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [itaf_pkg::VAL_W-1:0] value_i,
  input  logic                       wide_i,
  input  logic                       is_signed_i,
  input  logic                       kind_i,
  input  logic                       upper_case_i,
  input  logic                       hex_prefix_i,
  input  logic                       zero_pad_i,
  input  logic [7:0]                 field_width_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [7:0]                 char_out_o,
  output logic                       last_o
);

  itaf_pkg::ctl_t ctl;
  itaf_pkg::sts_t sts;

  itaf_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .in_ready_o (in_ready_o)
  );

  itaf_dp #(
    .OUT_LIMIT (OUT_LIMIT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .value_i       (value_i),
    .wide_i        (wide_i),
    .is_signed_i   (is_signed_i),
    .kind_i        (kind_i),
    .upper_case_i  (upper_case_i),
    .hex_prefix_i  (hex_prefix_i),
    .zero_pad_i    (zero_pad_i),
    .field_width_i (field_width_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_out_o    (char_out_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after an accept");

  a_idle_owes_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> sts.rem_zero)
    else $error("waiting for input with characters still owed");

  a_emit_is_owed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.fire && ctl.op == itaf_pkg::UOP_EMIT |-> !sts.rem_zero)
    else $error("character beat emitted beyond the run length");
`endif

endmodule

[tb/sv/tb_integer_to_ascii_formatter_top.sv]
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_top: self-checking bench for the formatter
// Sends directed and random integer conversions under random flow control
// and checks every character beat against a behavioral model of the layout.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FIELD_MAX    = itaf_pkg::OUT_LIMIT_DEF - 1;
  localparam int unsigned N_RANDOM     = 480;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned HOLD_AT      = 100;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned CALM_TAIL    = 40;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam bit KIND_DEC = 1'b0;
  localparam bit KIND_HEX = 1'b1;

  typedef struct packed {
    logic [itaf_pkg::VAL_W-1:0] value;
    logic                       wide;
    logic                       is_signed;
    logic                       kind;
    logic                       upper_case;
    logic                       hex_prefix;
    logic                       zero_pad;
    logic [7:0]                 field_width;
  } fmt_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } fmt_char_t;

  logic      clk_i     = 1'b0;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  fmt_req_t  offered   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic [7:0] out_char;
  logic      out_last;

  fmt_req_t  conv_q[$];
  fmt_char_t exp_chars[$];
  fmt_char_t head;

  int unsigned n_taken   = 0;
  int unsigned n_total   = 0;
  int unsigned n_bad     = 0;
  int unsigned n_cycles  = 0;
  int unsigned src_gap   = 0;
  int unsigned snk_gap   = 0;
  int unsigned hold_left = 0;
  int unsigned src_mode  = 1;
  int unsigned snk_mode  = 1;
  bit          hold_done = 1'b0;
  bit          calm      = 1'b0;

  integer_to_ascii_formatter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .value_i       (offered.value),
    .wide_i        (offered.wide),
    .is_signed_i   (offered.is_signed),
    .kind_i        (offered.kind),
    .upper_case_i  (offered.upper_case),
    .hex_prefix_i  (offered.hex_prefix),
    .zero_pad_i    (offered.zero_pad),
    .field_width_i (offered.field_width),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .char_out_o    (out_char),
    .last_o        (out_last)
  );

  function automatic fmt_req_t mk(logic [63:0] v, bit w, bit s, bit k, bit u, bit a, bit z,
                                  logic [7:0] fw);
    fmt_req_t r;
    r = '{value: v, wide: w, is_signed: s, kind: k, upper_case: u, hex_prefix: a,
          zero_pad: z, field_width: fw};
    return r;
  endfunction

  // Append the characters that one conversion produces to exp_chars.
  function automatic void format_number(fmt_req_t r);
    logic [63:0] mag;
    logic [63:0] base;
    logic [3:0]  d;
    logic [7:0]  letter;
    logic [7:0]  xch;
    logic [7:0]  digs[$];
    logic [7:0]  text[$];
    int unsigned fw;
    int unsigned nd;
    bit          minus;
    bit          pfx;
    mag = r.wide ? r.value : {32'd0, r.value[31:0]};
    minus = 1'b0;
    if (r.is_signed && r.kind == KIND_DEC && mag[r.wide ? 63 : 31]) begin
      minus = 1'b1;
      mag = -mag;
      if (!r.wide) begin
        mag[63:32] = '0;
      end
    end
    fw = (r.field_width > FIELD_MAX) ? FIELD_MAX : r.field_width;
    base = (r.kind == KIND_HEX) ? 64'd16 : 64'd10;
    letter = r.upper_case ? itaf_pkg::CH_UA : itaf_pkg::CH_LA;
    xch = r.upper_case ? itaf_pkg::CH_UX : itaf_pkg::CH_LX;
    // digits come out least significant first
    while (mag != 0) begin
      d = 4'(mag % base);
      mag = mag / base;
      digs.push_back((d < 4'd10) ? itaf_pkg::CH_ZERO + 8'(d) : letter + 8'(d - 4'd10));
    end
    if (digs.size() == 0) begin
      digs.push_back(itaf_pkg::CH_ZERO);
    end
    nd = digs.size();
    if (fw < nd) begin
      fw = nd;
    end
    pfx = (r.kind == KIND_HEX) && r.hex_prefix;
    if (r.zero_pad) begin
      if (minus) begin
        text.push_back(itaf_pkg::CH_MINUS);
      end
      if (pfx) begin
        text.push_back(itaf_pkg::CH_ZERO);
        text.push_back(xch);
      end
      while (text.size() < fw - nd) text.push_back(itaf_pkg::CH_ZERO);
    end else begin
      while (text.size() < fw - nd) text.push_back(itaf_pkg::CH_SPACE);
      // the sign takes the place of the last pad character
      if (minus && text.size() != 0) begin
        text[$] = itaf_pkg::CH_MINUS;
      end else if (minus) begin
        text.push_back(itaf_pkg::CH_MINUS);
      end
      if (pfx) begin
        text.push_back(itaf_pkg::CH_ZERO);
        text.push_back(xch);
      end
    end
    for (int i = nd - 1; i >= 0; i--) text.push_back(digs[i]);
    if (text.size() > FIELD_MAX) begin
      text = {};
      repeat (FIELD_MAX) text.push_back(itaf_pkg::CH_QUEST);
    end
    foreach (text[i]) begin
      exp_chars.push_back('{ch: text[i], last: (i == text.size() - 1)});
    end
  endfunction

  function automatic bit idle_hit(int unsigned mode);
    case (mode)
      1: return $urandom_range(0, 7) == 0;
      2: return $urandom_range(0, 2) == 0;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void log_error(string msg);
    n_bad++;
    if (n_bad <= MAX_REPORTS) begin
      $display("%0t ns: mismatch: %s", $realtime, msg);
    end
  endfunction

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Sender: offer conversions from conv_q, predict each one as it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      src_gap  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        format_number(offered);
        n_taken <= n_taken + 1;
        if ($urandom_range(0, 15) == 0) begin
          src_mode = $urandom_range(0, 2);
        end
      end
      calm <= conv_q.size() < CALM_TAIL;
      if (!in_valid || in_ready) begin
        if (src_gap != 0) begin
          in_valid <= 1'b0;
          src_gap  <= src_gap - 1;
        end else if (conv_q.size() != 0) begin
          offered  <= conv_q.pop_front();
          in_valid <= 1'b1;
          if (!calm && idle_hit(src_mode)) begin
            src_gap <= $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off once traffic is flowing; the sender keeps offering.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: check each character beat against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      snk_gap   <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_chars.size() == 0) begin
          log_error($sformatf("unexpected beat char 0x%02h last %0b", out_char, out_last));
        end else begin
          head = exp_chars.pop_front();
          if (out_char !== head.ch || out_last !== head.last) begin
            log_error($sformatf("char exp 0x%02h got 0x%02h, last exp %0b got %0b",
                                head.ch, out_char, head.last, out_last));
          end
        end
        if ($urandom_range(0, 31) == 0) begin
          snk_mode = $urandom_range(0, 2);
        end
      end
      if (snk_gap != 0) begin
        out_ready <= 1'b0;
        snk_gap   <= snk_gap - 1;
      end else if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && idle_hit(snk_mode)) begin
          snk_gap <= $urandom_range(1, 12);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    fmt_req_t r;
    // zero, plain and with the hex prefix
    conv_q.push_back(mk(64'd0, 0, 0, KIND_DEC, 0, 0, 0, 8'd0));
    conv_q.push_back(mk(64'd0, 0, 0, KIND_HEX, 0, 1, 0, 8'd0));
    // widest magnitudes
    conv_q.push_back(mk('1, 1, 0, KIND_DEC, 0, 0, 0, 8'd0));
    conv_q.push_back(mk('1, 1, 0, KIND_HEX, 1, 1, 0, 8'd0));
    conv_q.push_back(mk(64'h8000_0000_0000_0000, 1, 1, KIND_DEC, 0, 0, 0, 8'd0));
    conv_q.push_back(mk(64'hdead_beef_8000_0000, 0, 1, KIND_DEC, 0, 0, 0, 8'd0));
    conv_q.push_back(mk(64'h7fff_ffff_ffff_ffff, 1, 1, KIND_DEC, 0, 0, 1, 8'd62));
    conv_q.push_back(mk(64'hffff_ffff, 0, 0, KIND_DEC, 0, 0, 0, 8'd0));
    conv_q.push_back(mk('1, 1, 1, KIND_DEC, 1, 1, 0, 8'd0));
    // sign placement with both pad styles
    conv_q.push_back(mk(64'hffff_ffff, 0, 1, KIND_DEC, 0, 0, 0, 8'd8));
    conv_q.push_back(mk(64'hffff_ffff_ffff_fffb, 1, 1, KIND_DEC, 0, 0, 1, 8'd6));
    conv_q.push_back(mk(64'hffff_ff85, 0, 1, KIND_DEC, 0, 0, 0, 8'd4));
    conv_q.push_back(mk(64'hffff_ff85, 0, 1, KIND_DEC, 0, 0, 0, 8'd3));
    conv_q.push_back(mk(64'hffff_ff85, 0, 1, KIND_DEC, 0, 0, 0, 8'd61));
    // signed hex prints raw bits, decimal ignores the prefix request
    conv_q.push_back(mk(64'hffff_ffff, 0, 1, KIND_HEX, 0, 0, 0, 8'd0));
    conv_q.push_back(mk(64'd255, 0, 0, KIND_DEC, 0, 1, 0, 8'd0));
    conv_q.push_back(mk(64'h5555_5555_00ab_cdef, 0, 0, KIND_HEX, 0, 0, 0, 8'd0));
    // prefix inside and outside the field
    conv_q.push_back(mk(64'd255, 0, 0, KIND_HEX, 1, 1, 1, 8'd10));
    conv_q.push_back(mk(64'd255, 0, 0, KIND_HEX, 0, 1, 0, 8'd10));
    conv_q.push_back(mk(64'd9, 1, 1, KIND_HEX, 0, 1, 1, 8'd2));
    // clamped widths and text too long
    conv_q.push_back(mk(64'hff, 0, 0, KIND_HEX, 0, 1, 0, 8'd60));
    conv_q.push_back(mk(64'h1234, 1, 0, KIND_HEX, 1, 1, 0, 8'd255));
    conv_q.push_back(mk(64'd42, 0, 0, KIND_DEC, 0, 0, 1, 8'd255));
    conv_q.push_back(mk(64'd7, 0, 0, KIND_DEC, 0, 0, 0, 8'd62));

    for (int i = 0; i < N_RANDOM; i++) begin
      r.wide       = 1'($urandom);
      r.is_signed  = 1'($urandom);
      r.kind       = 1'($urandom);
      r.upper_case = 1'($urandom);
      r.hex_prefix = 1'($urandom);
      r.zero_pad   = 1'($urandom);
      case ($urandom_range(0, 9))
        0: r.value = {32'($urandom), 32'($urandom_range(0, 20))};
        1: begin
          case ($urandom_range(0, 5))
            0: r.value = '0;
            1: r.value = '1;
            2: r.value = 64'h8000_0000_0000_0000;
            3: r.value = 64'h7fff_ffff_ffff_ffff;
            4: r.value = {32'($urandom), 32'h8000_0000};
            default: r.value = {32'($urandom), 32'h7fff_ffff};
          endcase
        end
        default: r.value = {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
      endcase
      // negatives: negate about a quarter of the signed values
      if (r.is_signed && $urandom_range(0, 3) == 0) begin
        r.value = -r.value;
      end
      case ($urandom_range(0, 9))
        0: r.field_width = 8'($urandom_range(64, 255));
        1: r.field_width = 8'($urandom_range(55, 63));
        2: r.field_width = 8'd0;
        default: r.field_width = 8'($urandom_range(1, 24));
      endcase
      conv_q.push_back(r);
    end
    n_total = conv_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_taken != n_total || exp_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_bad == 0 && exp_chars.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
